>>> hw/rtl/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg: shared types and constants of the stereo keypoint matcher
// Opcodes, register indexes, sequencer states, band scale table, popcount.
// ----------------------------------------------------------------------------
package skm_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_HEIGHT   = 3'd0,
      CSR_ROW_TOLERANCE  = 3'd1,
      CSR_HAMMING_THRESH = 3'd2,
      CSR_LOWE_RATIO     = 3'd3,
      CSR_MIN_DISPARITY  = 3'd4,
      CSR_MAX_DISPARITY  = 3'd5,
      CSR_DEPTH_NUM      = 3'd6,
      CSR_SPARE          = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAND,
      ST_RANGE,
      ST_SCAN,
      ST_RATIO,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   localparam int DESC_BITS = 256;
   localparam int DIV_STEPS = 28;

   // 1.2^octave in Q16
   function automatic logic [17:0] band_scale(input logic [2:0] oct);
      logic [17:0] s;
      case (oct)
         3'd0: s = 18'd65536;
         3'd1: s = 18'd78643;
         3'd2: s = 18'd94372;
         3'd3: s = 18'd113246;
         3'd4: s = 18'd135895;
         3'd5: s = 18'd163075;
         3'd6: s = 18'd195689;
         3'd7: s = 18'd234827;
         default: s = 18'd65536;
      endcase
      return s;
   endfunction

   function automatic logic [8:0] popcount(input logic [DESC_BITS-1:0] v);
      logic [8:0] acc;
      acc = 9'd0;
      for (int i = 0; i < DESC_BITS; i++) begin
         acc = acc + 9'(v[i]);
      end
      return acc;
   endfunction

endpackage

>>> hw/rtl/stereo_keypoint_matcher_core.sv
// ----------------------------------------------------------------------------
// stereo_keypoint_matcher_core: epipolar band Hamming matcher with depth
// Stores right keypoints in RAM, scans them per left query, returns match.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | op, pos_x, pos_y, octave, desc
// rsp     | out       | rsp_valid/rsp_stall  | matched, index, column, distance, depth
// csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// Clear and load do not raise req_stall. A query holds req_stall while it
// scans the stored points: one RAM read per stored point, a short compare
// pipeline, then the ratio and disparity checks. An accepted match with
// nonzero disparity also runs the bit-serial depth divider.
// Reset is synchronous; it empties the table and restores register defaults.
// req_stall is high while a query runs and while its result waits for the slot.
// ----------------------------------------------------------------------------
module stereo_keypoint_matcher_core #(
   parameter int MAX_RIGHT_POINTS = 1024,
   parameter int OCTAVE_LEVELS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [2:0]  req_octave,
   input  logic [63:0] req_desc_word0,
   input  logic [63:0] req_desc_word1,
   input  logic [63:0] req_desc_word2,
   input  logic [63:0] req_desc_word3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   output logic [9:0]  rsp_right_index,
   output logic [11:0] rsp_right_column,
   output logic [8:0]  rsp_best_distance,
   output logic [15:0] rsp_depth_mm,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int AW = (MAX_RIGHT_POINTS > 1) ? $clog2(MAX_RIGHT_POINTS) : 1;
   localparam int CW = $clog2(MAX_RIGHT_POINTS + 1);

   // configuration
   logic [12:0] image_height_ff;
   logic [7:0]  row_tol_ff;
   logic [8:0]  ham_thr_ff;
   logic [8:0]  lowe_ff;
   logic [15:0] min_disp_ff;
   logic [15:0] max_disp_ff;
   logic [23:0] depth_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= 13'd480;
         row_tol_ff      <= 8'd32;
         ham_thr_ff      <= 9'd100;
         lowe_ff         <= 9'd204;
         min_disp_ff     <= 16'd0;
         max_disp_ff     <= 16'hFFFF;
         depth_num_ff    <= 24'd388800;
      end else if (csr_wr_en) begin
         case (skm_pkg::csr_index_type'(csr_index))
            skm_pkg::CSR_IMAGE_HEIGHT:   image_height_ff <= csr_wdata[12:0];
            skm_pkg::CSR_ROW_TOLERANCE:  row_tol_ff      <= csr_wdata[7:0];
            skm_pkg::CSR_HAMMING_THRESH: ham_thr_ff      <= csr_wdata[8:0];
            skm_pkg::CSR_LOWE_RATIO:     lowe_ff         <= csr_wdata[8:0];
            skm_pkg::CSR_MIN_DISPARITY:  min_disp_ff     <= csr_wdata[15:0];
            skm_pkg::CSR_MAX_DISPARITY:  max_disp_ff     <= csr_wdata[15:0];
            skm_pkg::CSR_DEPTH_NUM:      depth_num_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [12:0] h_eff;
   assign h_eff = (image_height_ff > 13'd4096) ? 13'd4096 : image_height_ff;

   // control
   skm_pkg::state_type state_ff, state_in;
   logic               accept;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      scan_ff;
   logic               s0_vld_ff, s1_vld_ff;
   logic [4:0]         div_cnt_ff;
   logic               match_ff;
   logic               rsp_valid_ff;

   assign req_stall = (state_ff != skm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   logic [12:0] ld_row;
   logic        ld_en;
   assign ld_row = 13'((17'(req_pos_y) + 17'd8) >> 4);
   assign ld_en  = accept && (skm_pkg::op_type'(req_op) == skm_pkg::OP_LOAD)
                   && (ld_row < h_eff) && (count_ff < CW'(MAX_RIGHT_POINTS));

   logic rd_en;
   assign rd_en = (state_ff == skm_pkg::ST_SCAN) && (scan_ff < count_ff);

   // RAMs
   logic [27:0]  pos_rd;
   logic [255:0] desc_rd;

   skm_ram #(.WIDTH(28), .DEPTH(MAX_RIGHT_POINTS), .AW(AW)) u_pos_ram (
      .clock   (clock),
      .wr_en   (ld_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_pos_x, ld_row[11:0]}),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (pos_rd)
   );

   skm_ram #(.WIDTH(256), .DEPTH(MAX_RIGHT_POINTS), .AW(AW)) u_desc_ram (
      .clock   (clock),
      .wr_en   (ld_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0}),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (desc_rd)
   );

   // query
   logic [15:0]  q_x_ff, q_y_ff;
   logic [2:0]   q_oct_ff;
   logic [255:0] q_desc_ff;
   logic [25:0]  band_ff;
   logic [11:0]  vmin_ff;
   logic [12:0]  vmax_ff;
   logic         empty_ff;

   logic [2:0]  oct_c;
   logic [17:0] scale_c;
   logic [25:0] band_in;
   assign oct_c   = ({1'b0, q_oct_ff} >= 4'(OCTAVE_LEVELS)) ? 3'(OCTAVE_LEVELS - 1) : q_oct_ff;
   assign scale_c = skm_pkg::band_scale(oct_c);
   assign band_in = {18'd0, row_tol_ff} * {8'd0, scale_c};

   logic [31:0] y20, lo_diff;
   logic [32:0] hi_sum;
   logic [11:0] vmin_in;
   logic [12:0] vmax_raw, vmax_in;
   assign y20      = {q_y_ff, 16'd0};
   assign lo_diff  = y20 - {6'd0, band_ff};
   assign vmin_in  = (y20 <= {6'd0, band_ff}) ? 12'd0 : lo_diff[31:20];
   assign hi_sum   = {1'b0, y20} + {7'd0, band_ff} + 33'h0_000F_FFFF;
   assign vmax_raw = hi_sum[32:20];
   assign vmax_in  = (vmax_raw > h_eff - 13'd1) ? h_eff - 13'd1 : vmax_raw;

   // scan pipeline
   logic [AW-1:0] s0_idx_ff, s1_idx_ff;
   logic [8:0]    s1_dist_ff;
   logic [11:0]   s1_row_ff;
   logic [15:0]   s1_col_ff;
   logic [11:0]   c_row;
   logic [15:0]   c_col;
   logic          c_take;
   assign c_row  = pos_rd[11:0];
   assign c_col  = pos_rd[27:12];
   assign c_take = s0_vld_ff && !empty_ff && (c_row >= vmin_ff) && ({1'b0, c_row} <= vmax_ff)
                   && ({1'b0, c_col} <= 17'(q_x_ff) + 17'd16);

   logic          have_best_ff, have_second_ff;
   logic [8:0]    best_ff, second_ff;
   logic [AW-1:0] best_idx_ff;
   logic [11:0]   best_row_ff;
   logic [15:0]   best_col_ff;

   // ratio and disparity
   logic [17:0]        prod_ff;
   logic [12:0]        ucol_ff;
   logic signed [17:0] disp_c;
   logic               pass_c;
   logic               zero_disp_ff;
   assign disp_c = $signed({2'b00, q_x_ff}) - $signed({1'b0, ucol_ff, 4'd0});
   assign pass_c = have_best_ff && (best_ff < ham_thr_ff)
                   && !(have_second_ff && ({best_ff, 8'd0} > {1'b0, prod_ff}))
                   && (disp_c >= $signed({2'b00, min_disp_ff}))
                   && (disp_c <= $signed({2'b00, max_disp_ff}));

   // divider
   logic [27:0] div_q_ff;
   logic [15:0] div_r_ff, div_d_ff;
   logic [17:0] trial;
   assign trial = {1'b0, div_r_ff, div_q_ff[27]} - {2'b00, div_d_ff};

   logic slot_free;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skm_pkg::ST_IDLE: begin
            if (accept && skm_pkg::op_type'(req_op) == skm_pkg::OP_QUERY) begin
               state_in = skm_pkg::ST_BAND;
            end
         end
         skm_pkg::ST_BAND:  state_in = skm_pkg::ST_RANGE;
         skm_pkg::ST_RANGE: state_in = skm_pkg::ST_SCAN;
         skm_pkg::ST_SCAN: begin
            if (scan_ff == count_ff && !s0_vld_ff && !s1_vld_ff) begin
               state_in = skm_pkg::ST_RATIO;
            end
         end
         skm_pkg::ST_RATIO: state_in = skm_pkg::ST_CHECK;
         skm_pkg::ST_CHECK: begin
            state_in = (pass_c && disp_c != 18'sd0) ? skm_pkg::ST_DIV : skm_pkg::ST_FINISH;
         end
         skm_pkg::ST_DIV: begin
            if (div_cnt_ff == 5'(skm_pkg::DIV_STEPS - 1)) begin
               state_in = skm_pkg::ST_FINISH;
            end
         end
         skm_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = skm_pkg::ST_IDLE;
            end
         end
         default: state_in = skm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skm_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && skm_pkg::op_type'(req_op) == skm_pkg::OP_CLEAR) begin
            count_ff <= '0;
         end else if (ld_en) begin
            count_ff <= count_ff + CW'(1);
         end
         if (state_ff == skm_pkg::ST_RANGE) begin
            scan_ff <= '0;
         end else if (rd_en) begin
            scan_ff <= scan_ff + CW'(1);
         end
         s0_vld_ff <= rd_en;
         s1_vld_ff <= c_take;
         if (state_ff == skm_pkg::ST_CHECK) begin
            div_cnt_ff <= '0;
         end else if (state_ff == skm_pkg::ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + 5'd1;
         end
         if (state_ff == skm_pkg::ST_FINISH && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   logic [27:0] depth_q;
   assign depth_q = (div_q_ff > 28'd65535) ? 28'd65535 : div_q_ff;

   logic [31:0] idx_ext;
   assign idx_ext = 32'(best_idx_ff);

   logic        rsp_matched_ff;
   logic [9:0]  rsp_index_ff;
   logic [11:0] rsp_column_ff;
   logic [8:0]  rsp_dist_ff;
   logic [15:0] rsp_depth_ff;

   always_ff @(posedge clock) begin
      if (accept && skm_pkg::op_type'(req_op) == skm_pkg::OP_QUERY) begin
         q_x_ff         <= req_pos_x;
         q_y_ff         <= req_pos_y;
         q_oct_ff       <= req_octave;
         q_desc_ff      <= {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
         have_best_ff   <= 1'b0;
         have_second_ff <= 1'b0;
      end
      if (state_ff == skm_pkg::ST_BAND) begin
         band_ff <= band_in;
      end
      if (state_ff == skm_pkg::ST_RANGE) begin
         vmin_ff  <= vmin_in;
         vmax_ff  <= vmax_in;
         empty_ff <= (h_eff == 13'd0);
      end
      s0_idx_ff  <= scan_ff[AW-1:0];
      s1_idx_ff  <= s0_idx_ff;
      s1_row_ff  <= c_row;
      s1_col_ff  <= c_col;
      s1_dist_ff <= skm_pkg::popcount(desc_rd ^ q_desc_ff);
      if (s1_vld_ff) begin
         if (!have_best_ff || s1_dist_ff < best_ff) begin
            if (have_best_ff) begin
               second_ff      <= best_ff;
               have_second_ff <= 1'b1;
            end
            best_ff      <= s1_dist_ff;
            best_idx_ff  <= s1_idx_ff;
            best_row_ff  <= s1_row_ff;
            best_col_ff  <= s1_col_ff;
            have_best_ff <= 1'b1;
         end else if (s1_dist_ff == best_ff) begin
            second_ff      <= s1_dist_ff;
            have_second_ff <= 1'b1;
            if (s1_row_ff < best_row_ff) begin
               best_idx_ff <= s1_idx_ff;
               best_row_ff <= s1_row_ff;
               best_col_ff <= s1_col_ff;
            end
         end else if (!have_second_ff || s1_dist_ff < second_ff) begin
            second_ff      <= s1_dist_ff;
            have_second_ff <= 1'b1;
         end
      end
      if (state_ff == skm_pkg::ST_RATIO) begin
         prod_ff <= {9'd0, lowe_ff} * {9'd0, second_ff};
         ucol_ff <= 13'((17'(best_col_ff) + 17'd8) >> 4);
      end
      if (state_ff == skm_pkg::ST_CHECK) begin
         match_ff     <= pass_c;
         zero_disp_ff <= (disp_c == 18'sd0);
         div_q_ff     <= {depth_num_ff, 4'd0};
         div_r_ff     <= 16'd0;
         div_d_ff     <= disp_c[15:0];
      end
      if (state_ff == skm_pkg::ST_DIV) begin
         if (!trial[17]) begin
            div_r_ff <= trial[15:0];
         end else begin
            div_r_ff <= {div_r_ff[14:0], div_q_ff[27]};
         end
         div_q_ff <= {div_q_ff[26:0], !trial[17]};
      end
      if (state_ff == skm_pkg::ST_FINISH && slot_free) begin
         rsp_matched_ff <= match_ff;
         rsp_index_ff   <= match_ff ? idx_ext[9:0] : 10'd0;
         rsp_column_ff  <= !match_ff ? 12'd0 :
                           (ucol_ff > 13'd4095) ? 12'd4095 : ucol_ff[11:0];
         rsp_dist_ff    <= match_ff ? best_ff : 9'd0;
         rsp_depth_ff   <= !match_ff ? 16'd0 :
                           zero_disp_ff ? 16'hFFFF : depth_q[15:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_right_index   = rsp_index_ff;
   assign rsp_right_column  = rsp_column_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_depth_mm      = rsp_depth_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RIGHT_POINTS))
      else $error("stored count above table size");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == skm_pkg::ST_FINISH))
      else $error("result raised outside finish");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(s0_vld_ff))
      else $error("candidate without read");

endmodule

>>> hw/rtl/skm_ram.sv
// ----------------------------------------------------------------------------
// skm_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stereo keypoint matcher core
// Loads right keypoints, runs left queries and checks every match result
// against an in-bench predictor of the band search, ratio test and depth.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      skm_pkg::op_type op;
      bit [15:0]       pos_x;
      bit [15:0]       pos_y;
      bit [2:0]        octave;
      bit [255:0]      desc;
   } keypoint_type;

   typedef struct packed {
      bit        matched;
      bit [9:0]  right_index;
      bit [11:0] right_column;
      bit [8:0]  best_distance;
      bit [15:0] depth_mm;
   } match_type;

   localparam int TABLE_SIZE = 1024;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int LONG_HOLD = 2500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = 2'd0;
   logic [15:0] req_pos_x = 16'd0;
   logic [15:0] req_pos_y = 16'd0;
   logic [2:0]  req_octave = 3'd0;
   logic [63:0] req_desc_word0 = 64'd0;
   logic [63:0] req_desc_word1 = 64'd0;
   logic [63:0] req_desc_word2 = 64'd0;
   logic [63:0] req_desc_word3 = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_matched;
   logic [9:0]  rsp_right_index;
   logic [11:0] rsp_right_column;
   logic [8:0]  rsp_best_distance;
   logic [15:0] rsp_depth_mm;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [23:0] csr_wdata = 24'd0;

   stereo_keypoint_matcher_core uut (.*);

   // predictor state
   bit [12:0]  image_height;
   bit [7:0]   band_tol;
   bit [8:0]   ham_limit;
   bit [8:0]   ratio_limit;
   bit [15:0]  disp_lo;
   bit [15:0]  disp_hi;
   bit [23:0]  depth_numerator;
   int         table_count;
   bit [15:0]  table_col [TABLE_SIZE];
   bit [12:0]  table_row [TABLE_SIZE];
   bit [255:0] table_desc [TABLE_SIZE];
   bit [17:0]  octave_scale [8] = '{18'd65536, 18'd78643, 18'd94372, 18'd113246,
                                    18'd135895, 18'd163075, 18'd195689, 18'd234827};

   match_type  pending_matches [$];
   int         error_count = 0;
   int         items_sent = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   logic       long_hold_req = 1'b0;
   logic       long_hold = 1'b0;
   longint     cycle_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < rx_idle_pct);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold <= 1'b0;
         end
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_matches.size() == 0) begin
            report("unexpected transaction", 1, 0);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_matched !== want.matched)
               report("matched", longint'(rsp_matched), longint'(want.matched));
            if (rsp_right_index !== want.right_index)
               report("right_index", longint'(rsp_right_index), longint'(want.right_index));
            if (rsp_right_column !== want.right_column)
               report("right_column", longint'(rsp_right_column),
                      longint'(want.right_column));
            if (rsp_best_distance !== want.best_distance)
               report("best_distance", longint'(rsp_best_distance),
                      longint'(want.best_distance));
            if (rsp_depth_mm !== want.depth_mm)
               report("depth_mm", longint'(rsp_depth_mm), longint'(want.depth_mm));
         end
      end
   end

   task automatic reset_predictor();
      image_height = 13'd480;
      band_tol = 8'd32;
      ham_limit = 9'd100;
      ratio_limit = 9'd204;
      disp_lo = 16'd0;
      disp_hi = 16'd65535;
      depth_numerator = 24'd388800;
      table_count = 0;
   endtask

   task automatic match_keypoint(input keypoint_type kp);
      int unsigned h, row, oct, hd, best, second, best_slot, best_row, ucol;
      longint unsigned band, y20, vmin, vmax, depth;
      longint disp;
      bit have_best, have_second;
      match_type m;
      h = (image_height > 4096) ? 4096 : image_height;
      row = (int'(kp.pos_y) + 8) >> 4;
      case (kp.op)
         skm_pkg::OP_CLEAR: table_count = 0;
         skm_pkg::OP_LOAD: begin
            if (row < h && table_count < TABLE_SIZE) begin
               table_col[table_count] = kp.pos_x;
               table_row[table_count] = 13'(row);
               table_desc[table_count] = kp.desc;
               table_count++;
            end
         end
         skm_pkg::OP_QUERY: begin
            oct = 32'(kp.octave);
            band = longint'(band_tol) * octave_scale[oct];
            y20 = longint'(kp.pos_y) << 16;
            vmin = (y20 <= band) ? 0 : ((y20 - band) >> 20);
            vmax = (y20 + band + 64'hFFFFF) >> 20;
            if (h == 0) begin
               vmin = 1;
               vmax = 0;
            end else if (vmax > h - 1) begin
               vmax = h - 1;
            end
            have_best = 0;
            have_second = 0;
            best = 0;
            second = 0;
            best_slot = 0;
            best_row = 0;
            for (int j = 0; j < table_count; j++) begin
               if (table_row[j] < vmin || table_row[j] > vmax) continue;
               if (int'(table_col[j]) > int'(kp.pos_x) + 16) continue;
               hd = $countones(table_desc[j] ^ kp.desc);
               if (!have_best || hd < best) begin
                  if (have_best) begin
                     second = best;
                     have_second = 1;
                  end
                  best = hd;
                  best_slot = j;
                  best_row = table_row[j];
                  have_best = 1;
               end else if (hd == best) begin
                  second = hd;
                  have_second = 1;
                  if (table_row[j] < best_row) begin
                     best_slot = j;
                     best_row = table_row[j];
                  end
               end else if (!have_second || hd < second) begin
                  second = hd;
                  have_second = 1;
               end
            end
            m = '0;
            if (have_best && best < ham_limit &&
                !(have_second && longint'(best) * 256 > longint'(ratio_limit) * second)) begin
               ucol = (int'(table_col[best_slot]) + 8) >> 4;
               disp = longint'(kp.pos_x) - longint'(ucol << 4);
               if (disp >= longint'(disp_lo) && disp <= longint'(disp_hi)) begin
                  if (disp == 0) depth = 65535;
                  else depth = (longint'(depth_numerator) << 4) / disp;
                  if (depth > 65535) depth = 65535;
                  m.matched = 1;
                  m.right_index = 10'(best_slot);
                  m.right_column = (ucol > 4095) ? 12'd4095 : 12'(ucol);
                  m.best_distance = 9'(best);
                  m.depth_mm = 16'(depth);
               end
            end
            pending_matches.insert(pending_matches.size(), m);
         end
         default: ;
      endcase
   endtask

   task automatic send_keypoint(input keypoint_type kp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= kp.op;
      req_pos_x <= kp.pos_x;
      req_pos_y <= kp.pos_y;
      req_octave <= kp.octave;
      req_desc_word0 <= kp.desc[63:0];
      req_desc_word1 <= kp.desc[127:64];
      req_desc_word2 <= kp.desc[191:128];
      req_desc_word3 <= kp.desc[255:192];
      do @(posedge clock); while (req_stall);
      match_keypoint(kp);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input skm_pkg::csr_index_type idx, input bit [23:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         skm_pkg::CSR_IMAGE_HEIGHT:   image_height = value[12:0];
         skm_pkg::CSR_ROW_TOLERANCE:  band_tol = value[7:0];
         skm_pkg::CSR_HAMMING_THRESH: ham_limit = value[8:0];
         skm_pkg::CSR_LOWE_RATIO:     ratio_limit = value[8:0];
         skm_pkg::CSR_MIN_DISPARITY:  disp_lo = value[15:0];
         skm_pkg::CSR_MAX_DISPARITY:  disp_hi = value[15:0];
         skm_pkg::CSR_DEPTH_NUM:      depth_numerator = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input bit [12:0] height, input bit [7:0] tol,
                             input bit [8:0] thresh, input bit [8:0] ratio,
                             input bit [15:0] dmin, input bit [15:0] dmax,
                             input bit [23:0] num);
      wait_idle();
      write_reg(skm_pkg::CSR_IMAGE_HEIGHT, 24'(height));
      write_reg(skm_pkg::CSR_ROW_TOLERANCE, 24'(tol));
      write_reg(skm_pkg::CSR_HAMMING_THRESH, 24'(thresh));
      write_reg(skm_pkg::CSR_LOWE_RATIO, 24'(ratio));
      write_reg(skm_pkg::CSR_MIN_DISPARITY, 24'(dmin));
      write_reg(skm_pkg::CSR_MAX_DISPARITY, 24'(dmax));
      write_reg(skm_pkg::CSR_DEPTH_NUM, num);
      csr_wr_en <= 1'b0;
   endtask

   function automatic bit [255:0] random_desc();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
   endfunction

   function automatic keypoint_type make_kp(input skm_pkg::op_type op, input int x,
                                            input int y, input int oct,
                                            input bit [255:0] desc);
      keypoint_type kp;
      kp.op = op;
      kp.pos_x = 16'(x);
      kp.pos_y = 16'(y);
      kp.octave = 3'(oct);
      kp.desc = desc;
      return kp;
   endfunction

   function automatic bit [255:0] flip_bits(input bit [255:0] desc, input int n);
      for (int i = 0; i < n; i++) desc[$urandom_range(255)] ^= 1'b1;
      return desc;
   endfunction

   // one scene: clear, load a cluster of right points, query near them
   task automatic run_scene();
      int h, base, n_load, n_query, slot, y, x;
      keypoint_type kp;
      h = (image_height > 4096) ? 4096 : image_height;
      base = $urandom_range(h - 1);
      n_load = $urandom_range(2, 24);
      n_query = $urandom_range(4, 12);
      send_keypoint(make_kp(skm_pkg::OP_CLEAR, 0, 0, 0, random_desc()));
      for (int i = 0; i < n_load; i++) begin
         if ($urandom_range(9) == 0)
            kp = make_kp(skm_pkg::OP_LOAD, $urandom, $urandom, $urandom, random_desc());
         else
            kp = make_kp(skm_pkg::OP_LOAD, $urandom_range(65535),
                         (base + $urandom_range(8)) * 16 + $urandom_range(15) - 8,
                         $urandom, random_desc());
         send_keypoint(kp);
      end
      for (int i = 0; i < n_query; i++) begin
         if ($urandom_range(9) == 0 || table_count == 0) begin
            kp = make_kp(skm_pkg::op_type'($urandom_range(3)), $urandom, $urandom,
                         $urandom, random_desc());
         end else begin
            slot = $urandom_range(table_count - 1);
            y = int'(table_row[slot]) * 16 + $urandom_range(64) - 32;
            x = int'(table_col[slot]) + $urandom_range(1200) - 16;
            if (y < 0) y = 0;
            if (y > 65535) y = 65535;
            if (x > 65535) x = 65535;
            kp = make_kp(skm_pkg::OP_QUERY, x, y, $urandom,
                         flip_bits(table_desc[slot], $urandom_range(70)));
         end
         send_keypoint(kp);
      end
   endtask

   task automatic run_scenes(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) run_scene();
   endtask

   task automatic test_directed();
      bit [255:0] d, e;
      d = random_desc();
      e = random_desc();
      send_keypoint(make_kp(skm_pkg::OP_CLEAR, 0, 0, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 100 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 90 * 16, 10 * 16 + 3, 0, flip_bits(d, 3)));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 95 * 16, 11 * 16 - 2, 5, d));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 50 * 16, 480 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 65528, 12 * 16, 0, e));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 300 * 16, 9 * 16, 0, ~d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 110 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 100 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 100 * 16 + 7, 11 * 16, 7, flip_bits(d, 40)));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 65535, 12 * 16, 0, e));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 65535, 65535, 7, 256'h0));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 0, 0, 0, {256{1'b1}}));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 80 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 400 * 16, 300 * 16, 2, d));
      send_keypoint(make_kp(skm_pkg::OP_NONE, 65535, 65535, 7, {256{1'b1}}));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 300 * 16, 9 * 16, 1, ~d));
      send_keypoint(make_kp(skm_pkg::OP_CLEAR, 0, 0, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 110 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_LOAD, 100 * 16, 10 * 16, 0, d));
      send_keypoint(make_kp(skm_pkg::OP_QUERY, 140 * 16, 10 * 16, 0, flip_bits(d, 99)));
   endtask

   task automatic test_registers();
      set_config(13'd1, 8'd255, 9'd257, 9'd256, 16'd0, 16'd65535, 24'hFFFFFF);
      run_scenes(30);
      set_config(13'd4096, 8'd0, 9'd0, 9'd0, 16'd65535, 16'd0, 24'd0);
      run_scenes(20);
      set_config(13'd8191, 8'd255, 9'd257, 9'd256, 16'd0, 16'd65535, 24'd0);
      run_scenes(30);
      set_config(13'd64, 8'd16, 9'd257, 9'd0, 16'd16, 16'd4000, 24'd1000);
      run_scenes(25);
      set_config(13'd300, 8'd48, 9'd120, 9'd230, 16'd32, 16'd12000, 24'd500000);
      run_scenes(30);
      set_config(13'd480, 8'd32, 9'd100, 9'd204, 16'd0, 16'd65535, 24'd388800);
   endtask

   task automatic test_idling();
      tx_idle_pct = 16;
      rx_idle_pct = 50;
      run_scenes(80);
      tx_idle_pct = 50;
      rx_idle_pct = 16;
      run_scenes(80);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_scenes(80);
   endtask

   task automatic test_backpressure();
      long_hold_req <= 1'b1;
      @(posedge clock);
      long_hold_req <= 1'b0;
      run_scenes(30);
      wait_idle();
      run_scenes(20);
   endtask

   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_idling();
      test_backpressure();
      wait_idle();
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> stereo_keypoint_matcher_core.f
hw/rtl/skm_pkg.sv
hw/rtl/skm_ram.sv
hw/rtl/stereo_keypoint_matcher_core.sv
tb/testbench.sv
